// ===== rtl/btlv_pkg.sv =====
// Shared types and constants for the BER-TLV header parser.
// No dependencies; used by every module under rtl/.
package btlv_pkg;

  localparam int FIELD_BYTES_DEF = 4;
  localparam int BYTE_W          = 8;
  localparam int ACC_W           = 32;
  localparam int CONS_W          = 8;
  localparam int LEFT_W          = 7;

  localparam logic [4:0]        TAG_MORE_MASK = 5'h1F;
  localparam logic [BYTE_W-1:0] LEN_INDEF     = 8'h80;
  localparam logic [BYTE_W-1:0] LEN_SHORT_MAX = 8'h7F;
  localparam logic [CONS_W-1:0] CONS_MAX      = 8'hFF;

  typedef enum logic [3:0] {
    PH_TAG0 = 4'b0001,
    PH_TAGN = 4'b0010,
    PH_LEN0 = 4'b0100,
    PH_LENN = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [ACC_W-1:0]  tag_value;
    logic [ACC_W-1:0]  length_value;
    logic [CONS_W-1:0] header_bytes;
    logic              indefinite;
    logic              overflow;
  } result_t;

endpackage

// ===== rtl/btlv_parse_core.sv =====
// Header parse state machine: tag and length accumulators, byte counters.
// Depends on btlv_pkg.
module btlv_parse_core #(
  parameter int FIELD_BYTES = btlv_pkg::FIELD_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step_i,
  input  logic [btlv_pkg::BYTE_W-1:0]   byte_i,
  input  logic                          restart_i,
  output logic                          emit_o,
  output btlv_pkg::result_t             res_o
);

  localparam int CNT_W = $clog2(FIELD_BYTES + 1);
  localparam logic [CNT_W-1:0] CNT_LIM = CNT_W'(FIELD_BYTES);

  btlv_pkg::phase_t                 phase_r, phase_nxt, phase_e;
  logic [btlv_pkg::ACC_W-1:0]       tag_r, tag_nxt, tag_e;
  logic [btlv_pkg::ACC_W-1:0]       len_r, len_nxt, len_e, len_shift;
  logic [btlv_pkg::LEFT_W-1:0]      left_r, left_nxt, left_e, left_dec;
  logic [CNT_W-1:0]                 tcnt_r, tcnt_nxt, tcnt_e;
  logic [CNT_W-1:0]                 lcnt_r, lcnt_nxt, lcnt_e;
  logic [btlv_pkg::CONS_W-1:0]      cons_r, cons_nxt, cons_e, cons_inc;
  logic                             ovf_r, ovf_nxt, ovf_e;
  logic                             emit;

  always_comb begin
    // restart drops the partial header before this byte is looked at
    if (restart_i) begin
      phase_e = btlv_pkg::PH_TAG0;
      tag_e   = '0;
      len_e   = '0;
      left_e  = '0;
      tcnt_e  = '0;
      lcnt_e  = '0;
      cons_e  = '0;
      ovf_e   = 1'b0;
    end else begin
      phase_e = phase_r;
      tag_e   = tag_r;
      len_e   = len_r;
      left_e  = left_r;
      tcnt_e  = tcnt_r;
      lcnt_e  = lcnt_r;
      cons_e  = cons_r;
      ovf_e   = ovf_r;
    end

    cons_inc  = (cons_e == btlv_pkg::CONS_MAX) ? cons_e : cons_e + 8'd1;
    len_shift = {len_e[btlv_pkg::ACC_W-btlv_pkg::BYTE_W-1:0], byte_i};
    left_dec  = (left_e != '0) ? left_e - 7'd1 : left_e;

    phase_nxt = phase_e;
    tag_nxt   = tag_e;
    len_nxt   = len_e;
    left_nxt  = left_e;
    tcnt_nxt  = tcnt_e;
    lcnt_nxt  = lcnt_e;
    cons_nxt  = cons_inc;
    ovf_nxt   = ovf_e;
    emit      = 1'b0;

    res_o.tag_value    = tag_e;
    res_o.length_value = '0;
    res_o.header_bytes = cons_inc;
    res_o.indefinite   = 1'b0;
    res_o.overflow     = ovf_e;

    case (phase_e)
      btlv_pkg::PH_TAG0: begin
        tag_nxt   = {{(btlv_pkg::ACC_W-btlv_pkg::BYTE_W){1'b0}}, byte_i};
        tcnt_nxt  = CNT_W'(1);
        phase_nxt = (byte_i[4:0] == btlv_pkg::TAG_MORE_MASK) ? btlv_pkg::PH_TAGN
                                                              : btlv_pkg::PH_LEN0;
      end
      btlv_pkg::PH_TAGN: begin
        tag_nxt = {tag_e[btlv_pkg::ACC_W-btlv_pkg::BYTE_W-1:0], byte_i};
        if (tcnt_e >= CNT_LIM) begin
          ovf_nxt = 1'b1;
        end else begin
          tcnt_nxt = tcnt_e + CNT_W'(1);
        end
        if (!byte_i[7]) begin
          phase_nxt = btlv_pkg::PH_LEN0;
        end
      end
      btlv_pkg::PH_LEN0: begin
        if (byte_i <= btlv_pkg::LEN_SHORT_MAX) begin
          emit = 1'b1;
          res_o.length_value = {{(btlv_pkg::ACC_W-btlv_pkg::BYTE_W){1'b0}}, byte_i};
        end else if (byte_i == btlv_pkg::LEN_INDEF) begin
          emit = 1'b1;
          res_o.indefinite = 1'b1;
        end else begin
          len_nxt   = '0;
          lcnt_nxt  = '0;
          left_nxt  = byte_i[btlv_pkg::LEFT_W-1:0];
          phase_nxt = btlv_pkg::PH_LENN;
        end
      end
      btlv_pkg::PH_LENN: begin
        len_nxt = len_shift;
        if (lcnt_e >= CNT_LIM) begin
          ovf_nxt = 1'b1;
        end else begin
          lcnt_nxt = lcnt_e + CNT_W'(1);
        end
        left_nxt = left_dec;
        res_o.length_value = len_shift;
        res_o.overflow     = ovf_nxt;
        emit = (left_dec == '0);
      end
      default: begin
        phase_nxt = btlv_pkg::PH_TAG0;
      end
    endcase

    // header done: back to the first tag byte with everything cleared
    if (emit) begin
      phase_nxt = btlv_pkg::PH_TAG0;
      tag_nxt   = '0;
      len_nxt   = '0;
      left_nxt  = '0;
      tcnt_nxt  = '0;
      lcnt_nxt  = '0;
      cons_nxt  = '0;
      ovf_nxt   = 1'b0;
    end
  end

  assign emit_o = step_i && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= btlv_pkg::PH_TAG0;
      tag_r   <= '0;
      len_r   <= '0;
      left_r  <= '0;
      tcnt_r  <= '0;
      lcnt_r  <= '0;
      cons_r  <= '0;
      ovf_r   <= 1'b0;
    end else if (step_i) begin
      phase_r <= phase_nxt;
      tag_r   <= tag_nxt;
      len_r   <= len_nxt;
      left_r  <= left_nxt;
      tcnt_r  <= tcnt_nxt;
      lcnt_r  <= lcnt_nxt;
      cons_r  <= cons_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // a header never completes on a byte that restarts it or in a tag phase
  a_emit_phase: assert property (@(posedge clk) disable iff (!rst_n)
    emit_o |-> !restart_i && (phase_r == btlv_pkg::PH_LEN0 || phase_r == btlv_pkg::PH_LENN))
    else $error("result emitted outside the length phases");

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    emit_o |=> phase_r == btlv_pkg::PH_TAG0 && cons_r == '0 && !ovf_r)
    else $error("state not cleared after a result");

  a_lenn_pending: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == btlv_pkg::PH_LENN |-> left_r != '0)
    else $error("long length phase with no bytes left");

  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    tcnt_r <= CNT_LIM && lcnt_r <= CNT_LIM)
    else $error("byte counter beyond field limit");

endmodule

// ===== rtl/btlv_out_buf.sv =====
// Two-entry result buffer: output register plus skid register.
// Depends on btlv_pkg.
module btlv_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_i,
  input  btlv_pkg::result_t push_data_i,
  output logic              full_o,
  output logic              out_valid,
  input  logic              out_stall,
  output btlv_pkg::result_t out_data_o
);

  logic              out_valid_r, skid_valid_r;
  btlv_pkg::result_t out_data_r, skid_data_r;
  logic              pop;

  assign pop       = out_valid_r && !out_stall;
  assign full_o    = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data_o = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push_i;
      end
    end else if (!out_valid_r) begin
      out_valid_r <= push_i;
    end else if (push_i) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_valid_r) begin
      out_data_r <= skid_data_r;
    end else if ((pop || !out_valid_r) && push_i) begin
      out_data_r <= push_data_i;
    end
    if (!pop && out_valid_r && push_i) begin
      skid_data_r <= push_data_i;
    end
  end

  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word held with empty output register");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> !skid_valid_r)
    else $error("result pushed into full buffer");

  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && !out_stall |=> out_valid_r && !skid_valid_r)
    else $error("skid word not moved up on pop");

endmodule

// ===== rtl/ber_tlv_header_parser_top.sv =====
// BER-TLV header parser, top level.
// Depends on btlv_pkg, btlv_parse_core, btlv_out_buf.
//
// Feed the header bytes of BER-TLV items one word per cycle on the in_ channel;
// one result word (tag, length, header byte count, indefinite and overflow
// flags) comes out on the out_ channel after the last header byte. Throughput
// is one byte per cycle while in_stall is low: the next parse state (phase,
// tag/length shift-or, counters) comes combinationally from each byte. An
// accepted byte is held in the input register; its result is registered in
// the two-word result buffer, which lets input flow while a result waits;
// in_stall rises only when both buffer words are occupied. in_restart drops
// any partial header and takes the byte as a first tag byte. Tags or lengths
// longer than FIELD_BYTES bytes keep their low 32 bits and set overflow.
module ber_tlv_header_parser_top #(
  parameter int FIELD_BYTES = btlv_pkg::FIELD_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [btlv_pkg::BYTE_W-1:0]   in_data_byte,
  input  logic                          in_restart,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [btlv_pkg::ACC_W-1:0]    out_tag_value,
  output logic [btlv_pkg::ACC_W-1:0]    out_length_value,
  output logic [btlv_pkg::CONS_W-1:0]   out_header_bytes,
  output logic                          out_indefinite,
  output logic                          out_overflow
);

  // input register
  logic                        in_valid_r;
  logic [btlv_pkg::BYTE_W-1:0] in_byte_r;
  logic                        in_restart_r;

  logic              buf_full;
  logic              step;
  logic              emit;
  btlv_pkg::result_t res;
  btlv_pkg::result_t out_data;

  // input register moves only when the buffer can take a result
  assign in_stall = buf_full;
  assign step     = in_valid_r && !buf_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!buf_full) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!buf_full) begin
      in_byte_r    <= in_data_byte;
      in_restart_r <= in_restart;
    end
  end

  btlv_parse_core #(
    .FIELD_BYTES (FIELD_BYTES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_i    (step),
    .byte_i    (in_byte_r),
    .restart_i (in_restart_r),
    .emit_o    (emit),
    .res_o     (res)
  );

  btlv_out_buf u_buf (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (emit),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data_o  (out_data)
  );

  assign out_tag_value    = out_data.tag_value;
  assign out_length_value = out_data.length_value;
  assign out_header_bytes = out_data.header_bytes;
  assign out_indefinite   = out_data.indefinite;
  assign out_overflow     = out_data.overflow;

endmodule

// ===== tb/ber_tlv_header_parser_top_test.sv =====
// Self-checking bench for ber_tlv_header_parser_top: directed header table, then random headers.
// Predicts tag/length/flags per accepted byte and compares each result word in order.
// Depends on btlv_pkg and the rtl/ top level only.
`timescale 1ns / 100ps

module ber_tlv_header_parser_top_test;

  localparam int FIELD_BYTES = btlv_pkg::FIELD_BYTES_DEF;
  localparam int RAND_BYTES  = 750;   // stop feeding random headers after this many bytes
  localparam int IDLE_LIMIT  = 2000;  // cycles with no handshake on either side
  localparam int DRAIN_WAIT  = 8;     // extra cycles waited after the expected-result queue empties

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT
  // ---------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_restart = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_tag_value;
  logic [31:0] out_length_value;
  logic [7:0]  out_header_bytes;
  logic        out_indefinite;
  logic        out_overflow;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ber_tlv_header_parser_top #(.FIELD_BYTES(FIELD_BYTES)) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_restart       (in_restart),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_tag_value    (out_tag_value),
    .out_length_value (out_length_value),
    .out_header_bytes (out_header_bytes),
    .out_indefinite   (out_indefinite),
    .out_overflow     (out_overflow)
  );

  // ---------------------------------------------------------------------------
  // Header predictor: own copy of the parse state, advanced once per accepted
  // word. A completed header yields one result, then the state clears.
  // ---------------------------------------------------------------------------
  btlv_pkg::phase_t ph;
  logic [31:0] tag_acc, len_acc;
  logic [6:0]  len_left;
  logic [3:0]  tag_cnt, len_cnt;   // saturate at FIELD_BYTES
  logic [7:0]  hdr_cnt;            // saturates at 255
  logic        ovf;

  btlv_pkg::result_t parsed_hdr_q[$];   // headers predicted but not yet seen on out_

  function automatic void clear_parse_state();
    ph       = btlv_pkg::PH_TAG0;
    tag_acc  = '0;
    len_acc  = '0;
    len_left = '0;
    tag_cnt  = '0;
    len_cnt  = '0;
    hdr_cnt  = '0;
    ovf      = 1'b0;
  endfunction

  function automatic btlv_pkg::result_t finish_header(input logic [31:0] len,
                                                      input logic indef);
    btlv_pkg::result_t r;
    r.tag_value    = tag_acc;
    r.length_value = len;
    r.header_bytes = hdr_cnt;
    r.indefinite   = indef;
    r.overflow     = ovf;
    clear_parse_state();
    return r;
  endfunction

  // returns 1 when this byte completes a header; r then holds the result
  function automatic bit decode_header_byte(input logic [7:0] b, input logic rs,
                                            output btlv_pkg::result_t r);
    r = '0;
    if (rs) clear_parse_state();
    if (hdr_cnt != btlv_pkg::CONS_MAX) hdr_cnt++;
    case (ph)
      btlv_pkg::PH_TAG0: begin
        tag_acc = {24'd0, b};
        tag_cnt = 4'd1;
        ph = (b[4:0] == btlv_pkg::TAG_MORE_MASK) ? btlv_pkg::PH_TAGN : btlv_pkg::PH_LEN0;
      end
      btlv_pkg::PH_TAGN: begin
        tag_acc = {tag_acc[23:0], b};
        if (tag_cnt >= FIELD_BYTES) ovf = 1'b1;
        else tag_cnt++;
        if (!b[7]) ph = btlv_pkg::PH_LEN0;
      end
      btlv_pkg::PH_LEN0: begin
        if (b <= btlv_pkg::LEN_SHORT_MAX) begin
          r = finish_header({24'd0, b}, 1'b0);
          return 1'b1;
        end
        if (b == btlv_pkg::LEN_INDEF) begin
          r = finish_header('0, 1'b1);
          return 1'b1;
        end
        // long form: low 7 bits count the length bytes (0xFF -> 127 of them)
        len_acc  = '0;
        len_cnt  = '0;
        len_left = b[6:0];
        ph       = btlv_pkg::PH_LENN;
      end
      default: begin
        len_acc = {len_acc[23:0], b};
        // leading zero bytes still count toward overflow
        if (len_cnt >= FIELD_BYTES) ovf = 1'b1;
        else len_cnt++;
        if (len_left != 0) len_left--;
        if (len_left == 0) begin
          r = finish_header(len_acc, 1'b0);
          return 1'b1;
        end
      end
    endcase
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Bookkeeping
  // ---------------------------------------------------------------------------
  int n_err = 0;
  int n_sent = 0;
  int n_restart = 0;
  int n_results = 0;
  int n_indef = 0;
  int n_ovf = 0;
  int n_satur = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;   // no gaps, no stalls while set

  task automatic fail_note(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    n_err++;
  endtask

  // ---------------------------------------------------------------------------
  // Input driver. Called at a rising edge; returns at the edge where the word
  // was taken. Handshake is sampled at the falling edge, so no race with the
  // DUT's own updates.
  // ---------------------------------------------------------------------------
  task automatic feed_byte(input logic [7:0] b, input logic rs,
                           input bit use_typed, input btlv_pkg::result_t typed_r);
    int gap;
    int pick;
    btlv_pkg::result_t r;
    bit done;
    gap = 0;
    if (!calm) begin
      pick = $urandom_range(0, 99);
      if (pick >= 92)      gap = $urandom_range(10, 30);
      else if (pick >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_restart   <= rs;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    // word accepted at this edge
    n_sent++;
    if (rs) n_restart++;
    done = decode_header_byte(b, rs, r);
    if (use_typed) parsed_hdr_q.push_back(typed_r);
    else if (done) parsed_hdr_q.push_back(r);
  endtask

  // One random header: mostly well formed with random content. May be cut
  // short, in which case the caller restarts the next header.
  task automatic send_header(input int idx, input logic rs_first, output bit cut_short);
    logic [8:0]  seq[$];
    logic [7:0]  b;
    logic [7:0]  lead;
    int          n_tag, n_len, form, cut, i;
    bit          forced;
    forced = (idx == 12) || (idx == 25);
    lead = 8'($urandom);
    if (idx == 12 || $urandom_range(0, 2) == 0) lead[4:0] = btlv_pkg::TAG_MORE_MASK;
    seq.push_back({rs_first, lead});
    if (lead[4:0] == btlv_pkg::TAG_MORE_MASK) begin
      // one very long tag pushes the header byte count into saturation
      if (idx == 12)                      n_tag = 260;
      else if ($urandom_range(0, 9) == 0) n_tag = $urandom_range(4, 7);
      else                                n_tag = $urandom_range(1, 3);
      for (i = 1; i <= n_tag; i++) begin
        b = 8'($urandom);
        b[7] = (i != n_tag);
        seq.push_back({1'b0, b});
      end
    end
    form = (idx == 25) ? 9 : $urandom_range(0, 9);
    if (form < 4) begin
      seq.push_back({1'b0, 8'($urandom_range(0, 127))});
    end else if (form == 4) begin
      seq.push_back({1'b0, btlv_pkg::LEN_INDEF});
    end else begin
      // long form; idx 25 uses first length byte 0xFF (127 bytes follow)
      if (idx == 25)                      n_len = 127;
      else if ($urandom_range(0, 5) == 0) n_len = $urandom_range(5, 8);
      else                                n_len = $urandom_range(1, 4);
      seq.push_back({1'b0, 1'b1, 7'(n_len)});
      for (i = 0; i < n_len; i++) begin
        b = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
        seq.push_back({1'b0, b});
      end
    end
    cut_short = 1'b0;
    if (!forced && seq.size() > 1 && $urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, seq.size() - 1);
      while (seq.size() > cut) void'(seq.pop_back());
      cut_short = 1'b1;
    end
    foreach (seq[k]) feed_byte(seq[k][7:0], seq[k][8], 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts, short mostly, some long, none when calm.
  // ---------------------------------------------------------------------------
  int stall_run = 0;

  always @(posedge clk) begin
    int pick;
    if (calm) begin
      out_stall <= 1'b0;
      stall_run = 0;
    end else if (stall_run > 0) begin
      stall_run--;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        out_stall <= 1'b0;
        stall_run = $urandom_range(1, 8);
      end else if (pick < 90) begin
        out_stall <= 1'b1;
        stall_run = $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b1;
        stall_run = $urandom_range(10, 30);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker and watchdog. Sampled at the falling edge; a word counts as
  // taken when valid is high and stall low ahead of the next rising edge.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    btlv_pkg::result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (parsed_hdr_q.size() == 0) begin
          fail_note($sformatf("result with none expected: tag %h len %h",
                              out_tag_value, out_length_value));
        end else begin
          want = parsed_hdr_q.pop_front();
          n_results++;
          if (want.indefinite) n_indef++;
          if (want.overflow) n_ovf++;
          if (want.header_bytes == btlv_pkg::CONS_MAX) n_satur++;
          if (out_tag_value !== want.tag_value)
            fail_note($sformatf("result %0d tag_value got %h want %h",
                                n_results, out_tag_value, want.tag_value));
          if (out_length_value !== want.length_value)
            fail_note($sformatf("result %0d length_value got %h want %h",
                                n_results, out_length_value, want.length_value));
          if (out_header_bytes !== want.header_bytes)
            fail_note($sformatf("result %0d header_bytes got %0d want %0d",
                                n_results, out_header_bytes, want.header_bytes));
          if (out_indefinite !== want.indefinite)
            fail_note($sformatf("result %0d indefinite got %b want %b",
                                n_results, out_indefinite, want.indefinite));
          if (out_overflow !== want.overflow)
            fail_note($sformatf("result %0d overflow got %b want %b",
                                n_results, out_overflow, want.overflow));
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no handshake for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, parsed_hdr_q.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table. typed=1 rows carry a hand-written result; all other rows
  // go through the predictor.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [7:0]  b;
    logic        rs;
    logic        typed;
    logic [31:0] tag;
    logic [31:0] len;
    logic [7:0]  hb;
    logic        ind;
    logic        ov;
  } dir_row_t;

  dir_row_t dir_tab [24];

  initial begin
    bit cut;
    bit rs;
    int idx;
    btlv_pkg::result_t r;

    dir_tab = '{
      // all-zero header: tag 00, short length 00
      '{8'h00, 1'b0, 1'b0, 32'h0, 32'h0, 8'd0, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b1, 32'h0000_0000, 32'h0000_0000, 8'd2, 1'b0, 1'b0},
      // three-byte tag, largest short-form length
      '{8'h1F, 1'b0, 1'b0, 32'h0, 32'h0, 8'd0, 1'b0, 1'b0},
      '{8'h81, 1'b0, 1'b0, 32'h0, 32'h0, 8'd0, 1'b0, 1'b0},
      '{8'h7F, 1'b0, 1'b0, 32'h0, 32'h0, 8'd0, 1'b0, 1'b0},
      '{8'h7F, 1'b0, 1'b1, 32'h001F_817F, 32'h0000_007F, 8'd4, 1'b0, 1'b0},
      // indefinite length
      '{8'h02, 1'b0, 1'b0, 32'h0, 32'h0, 8'd0, 1'b0, 1'b0},
      '{8'h80, 1'b0, 1'b1, 32'h0000_0002, 32'h0000_0000, 8'd2, 1'b1, 1'b0},
      // six-byte tag (overflow), four all-ones length bytes
      '{8'hFF, 1'b0, 1'b0, 32'h0, 32'h0, 8'd0, 1'b0, 1'b0},
      '{8'hFF, 1'b0, 1'b0, 32'h0, 32'h0, 8'd0, 1'b0, 1'b0},
      '{8'hFF, 1'b0, 1'b0, 32'h0, 32'h0, 8'd0, 1'b0, 1'b0},
      '{8'hFF, 1'b0, 1'b0, 32'h0, 32'h0, 8'd0, 1'b0, 1'b0},
      '{8'hFF, 1'b0, 1'b0, 32'h0, 32'h0, 8'd0, 1'b0, 1'b0},
      '{8'h7F, 1'b0, 1'b0, 32'h0, 32'h0, 8'd0, 1'b0, 1'b0},
      '{8'h84, 1'b0, 1'b0, 32'h0, 32'h0, 8'd0, 1'b0, 1'b0},
      '{8'hFF, 1'b0, 1'b0, 32'h0, 32'h0, 8'd0, 1'b0, 1'b0},
      '{8'hFF, 1'b0, 1'b0, 32'h0, 32'h0, 8'd0, 1'b0, 1'b0},
      '{8'hFF, 1'b0, 1'b0, 32'h0, 32'h0, 8'd0, 1'b0, 1'b0},
      '{8'hFF, 1'b0, 1'b1, 32'hFFFF_FF7F, 32'hFFFF_FFFF, 8'd11, 1'b0, 1'b1},
      // partial multi-byte tag dropped by restart, then a fresh header
      '{8'h3F, 1'b0, 1'b0, 32'h0, 32'h0, 8'd0, 1'b0, 1'b0},
      '{8'h85, 1'b0, 1'b0, 32'h0, 32'h0, 8'd0, 1'b0, 1'b0},
      '{8'h05, 1'b1, 1'b0, 32'h0, 32'h0, 8'd0, 1'b0, 1'b0},
      '{8'h81, 1'b0, 1'b0, 32'h0, 32'h0, 8'd0, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 32'h0, 32'h0, 8'd0, 1'b0, 1'b0}
    };

    clear_parse_state();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      r.tag_value    = dir_tab[i].tag;
      r.length_value = dir_tab[i].len;
      r.header_bytes = dir_tab[i].hb;
      r.indefinite   = dir_tab[i].ind;
      r.overflow     = dir_tab[i].ov;
      feed_byte(dir_tab[i].b, dir_tab[i].rs, dir_tab[i].typed, r);
    end

    // Random headers. Header 12 has a 261-byte tag, header 25 a 0xFF length
    // byte; headers 50..69 run back to back with no stalls.
    idx = 0;
    cut = 1'b0;
    while (n_sent < RAND_BYTES) begin
      calm = (idx >= 50 && idx < 70);
      if (idx != 12 && idx != 25 && $urandom_range(0, 19) == 0) begin
        // noise: a few arbitrary words, restart bit random
        repeat ($urandom_range(1, 3))
          feed_byte(8'($urandom), 1'($urandom), 1'b0, '0);
      end
      rs = cut || ($urandom_range(0, 7) == 0);
      send_header(idx, rs, cut);
      idx++;
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // drain; the watchdog ends the run if results stop coming
    while (parsed_hdr_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (parsed_hdr_q.size() != 0)
      fail_note($sformatf("%0d results never arrived", parsed_hdr_q.size()));

    $display("Fed %0d header bytes (%0d with restart) over %0d random headers.",
             n_sent, n_restart, idx);
    $display("Checked %0d results: %0d indefinite, %0d overflow, %0d saturated counts.",
             n_results, n_indef, n_ovf, n_satur);
    if (n_err == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", n_err);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/btlv_pkg.sv
rtl/btlv_parse_core.sv
rtl/btlv_out_buf.sv
rtl/ber_tlv_header_parser_top.sv
tb/ber_tlv_header_parser_top_test.sv
